/* rtl/hbrp_pkg.sv */
// Shared types, constants and per-character scan helpers for the byte-range parser.
package hbrp_pkg;

    localparam int unsigned NUM_W = 63;

    localparam logic [NUM_W-1:0] MAX63 = {NUM_W{1'b1}};

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_LEFT   = 3'b010,
        PH_RIGHT  = 3'b100
    } phase_t;

    typedef enum logic [4:0] {
        SC_WS    = 5'b00001,
        SC_SIGN  = 5'b00010,
        SC_DIG   = 5'b00100,
        SC_NODIG = 5'b01000,
        SC_END   = 5'b10000
    } scan_t;

    typedef struct packed {
        logic [7:0]       header_byte;
        logic             byte_present;
        logic             is_last;
        logic [NUM_W-1:0] file_len;
    } hbrp_in_t;

    typedef struct packed {
        logic             range_ok;
        logic [NUM_W-1:0] first_byte;
        logic [NUM_W-1:0] last_byte;
    } hbrp_out_t;

    // one stoll-style number scanner
    typedef struct packed {
        scan_t            scan;
        logic [NUM_W-1:0] value;
        logic             negative;
        logic             overflow;
    } hbrp_num_t;

    typedef struct packed {
        phase_t    phase;
        logic [2:0] prefix_pos;
        logic      prefix_failed;
        logic      comma_seen;
        logic      left_blank;
        logic      right_blank;
        hbrp_num_t left;
        hbrp_num_t right;
    } hbrp_state_t;

    // parse state captured on the final beat, with the file size
    typedef struct packed {
        hbrp_state_t      st;
        logic [NUM_W-1:0] file_len;
    } hbrp_snap_t;

    localparam hbrp_num_t NUM_RESET = '{
        scan:     SC_WS,
        value:    '0,
        negative: 1'b0,
        overflow: 1'b0
    };

    localparam hbrp_state_t STATE_RESET = '{
        phase:         PH_PREFIX,
        prefix_pos:    3'd0,
        prefix_failed: 1'b0,
        comma_seen:    1'b0,
        left_blank:    1'b1,
        right_blank:   1'b1,
        left:          NUM_RESET,
        right:         NUM_RESET
    };

    // "bytes="
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // advance one number scanner by one character
    function automatic hbrp_num_t scan_step(input hbrp_num_t cur, input logic [7:0] c);
        hbrp_num_t       nx;
        logic            digit;
        logic            ws;
        logic            take;
        logic [NUM_W+3:0] acc;
        nx    = cur;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        take  = 1'b0;
        unique case (cur.scan) inside
            SC_WS: begin
                if (ws) begin
                    take = 1'b0;
                end else if ((c == CH_PLUS) || (c == CH_DASH)) begin
                    nx.negative = (c == CH_DASH);
                    nx.scan     = SC_SIGN;
                end else if (!digit) begin
                    nx.scan = SC_NODIG;
                end else begin
                    take = 1'b1;
                end
            end
            SC_SIGN, SC_DIG: begin
                if (!digit) begin
                    nx.scan = (cur.scan == SC_DIG) ? SC_END : SC_NODIG;
                end else begin
                    take = 1'b1;
                end
            end
            default: take = 1'b0;
        endcase
        // value*10 + digit; value never exceeds 2^63-1 so 67 bits hold it
        acc = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0}
            + {{(NUM_W){1'b0}}, c[3:0]};
        if (take) begin
            nx.scan = SC_DIG;
            if (!cur.overflow) begin
                if (acc > {4'b0000, MAX63}) begin
                    nx.overflow = 1'b1;
                end else begin
                    nx.value = acc[NUM_W-1:0];
                end
            end
        end
        return nx;
    endfunction

endpackage

/* rtl/hbrp_parse.sv */
// Per-character header parse state: prefix match, dash split and two number scanners.
module hbrp_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  hbrp_pkg::hbrp_in_t   item,
    output hbrp_pkg::hbrp_state_t st_next
);

    hbrp_pkg::hbrp_state_t st_reg;

    always_comb begin
        st_next = st_reg;
        if (item.byte_present) begin
            unique case (st_reg.phase)
                hbrp_pkg::PH_PREFIX: begin
                    if (item.header_byte != hbrp_pkg::prefix_char(st_reg.prefix_pos)) begin
                        st_next.prefix_failed = 1'b1;
                    end
                    st_next.prefix_pos = st_reg.prefix_pos + 3'd1;
                    if (st_reg.prefix_pos == hbrp_pkg::PREFIX_LEN - 3'd1) begin
                        st_next.phase = hbrp_pkg::PH_LEFT;
                    end
                end
                hbrp_pkg::PH_LEFT: begin
                    if (item.header_byte == hbrp_pkg::CH_COMMA) begin
                        st_next.comma_seen = 1'b1;
                    end
                    if (item.header_byte == hbrp_pkg::CH_DASH) begin
                        st_next.phase = hbrp_pkg::PH_RIGHT;
                    end else begin
                        if (item.header_byte != hbrp_pkg::CH_SPACE) begin
                            st_next.left_blank = 1'b0;
                        end
                        st_next.left = hbrp_pkg::scan_step(st_reg.left, item.header_byte);
                    end
                end
                hbrp_pkg::PH_RIGHT: begin
                    if (item.header_byte == hbrp_pkg::CH_COMMA) begin
                        st_next.comma_seen = 1'b1;
                    end
                    if (item.header_byte != hbrp_pkg::CH_SPACE) begin
                        st_next.right_blank = 1'b0;
                    end
                    st_next.right = hbrp_pkg::scan_step(st_reg.right, item.header_byte);
                end
                default: st_next = st_reg;
            endcase
        end
    end

    // state returns to reset after every final beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= hbrp_pkg::STATE_RESET;
        end else if (adv) begin
            st_reg <= item.is_last ? hbrp_pkg::STATE_RESET : st_next;
        end
    end

endmodule

/* rtl/hbrp_resolve.sv */
// Turns a captured parse state and file size into the final byte range.
module hbrp_resolve (
    input  hbrp_pkg::hbrp_snap_t snap,
    output hbrp_pkg::hbrp_out_t  result
);

    logic [hbrp_pkg::NUM_W-1:0] f;
    logic [hbrp_pkg::NUM_W-1:0] a;
    logic [hbrp_pkg::NUM_W-1:0] b;
    logic                       gen_fail;
    logic                       left_ok;
    logic                       right_ok;
    logic                       left_bad;
    logic                       right_bad;

    assign f = snap.file_len;
    assign a = snap.st.left.value;
    assign b = snap.st.right.value;

    assign gen_fail = (f == '0) || snap.st.prefix_failed || snap.st.comma_seen
                   || (snap.st.phase != hbrp_pkg::PH_RIGHT)
                   || (snap.st.left_blank && snap.st.right_blank);

    assign left_ok  = !snap.st.left.overflow
                   && ((snap.st.left.scan == hbrp_pkg::SC_DIG)
                    || (snap.st.left.scan == hbrp_pkg::SC_END));
    assign right_ok = !snap.st.right.overflow
                   && ((snap.st.right.scan == hbrp_pkg::SC_DIG)
                    || (snap.st.right.scan == hbrp_pkg::SC_END));
    // minus zero reads as zero
    assign left_bad  = snap.st.left.negative && (a != '0);
    assign right_bad = snap.st.right.negative && (b != '0);

    always_comb begin
        result = '0;
        if (!gen_fail) begin
            if (snap.st.left_blank) begin
                // suffix form: last b bytes
                if (right_ok && !right_bad && (b != '0)) begin
                    result.range_ok   = 1'b1;
                    result.first_byte = (b >= f) ? '0 : (f - b);
                    result.last_byte  = f - {{(hbrp_pkg::NUM_W-1){1'b0}}, 1'b1};
                end
            end else if (left_ok && !left_bad && (a < f)) begin
                if (snap.st.right_blank) begin
                    result.range_ok   = 1'b1;
                    result.first_byte = a;
                    result.last_byte  = f - {{(hbrp_pkg::NUM_W-1){1'b0}}, 1'b1};
                end else if (right_ok && !right_bad && (b >= a)) begin
                    result.range_ok   = 1'b1;
                    result.first_byte = a;
                    result.last_byte  = (b >= f) ? (f - {{(hbrp_pkg::NUM_W-1){1'b0}}, 1'b1})
                                                 : b;
                end
            end
        end
    end

endmodule

/* rtl/http_byte_range_parser_unit.sv */
// Top level of the HTTP single byte-range header parser.
// The Range header streams in one character per input beat; the beat with is_last set
// also carries the file size and produces exactly one result beat (range_ok, first_byte,
// last_byte; offsets zero when rejected). One input beat is taken every clock cycle while
// no final beat is held in the input register waiting for room downstream. A final beat
// sits in the input register while the character parser folds it into the parse state
// (its multiply-by-ten accumulate into a 63-bit value is the longest path) and the
// outcome lands in the snapshot register; from there the range resolver (63-bit
// compares and subtracts against the file size) feeds the result register that drives
// m_valid. The beat in the input register only waits when it is final and both the snapshot
// and result registers are full with m_ready low; while it waits, s_ready stays low.
module http_byte_range_parser_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hbrp_pkg::hbrp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hbrp_pkg::hbrp_out_t m_data
);

    // input register
    hbrp_pkg::hbrp_in_t    in_reg;
    logic                  in_valid_reg;
    // final-beat snapshot
    hbrp_pkg::hbrp_snap_t  snap_reg;
    logic                  snap_valid_reg;
    // result register
    hbrp_pkg::hbrp_out_t   out_reg;
    logic                  out_valid_reg;

    hbrp_pkg::hbrp_state_t st_next;
    hbrp_pkg::hbrp_out_t   result;

    logic out_free;
    logic snap_free;
    logic in_adv;
    logic in_free;

    // backward-flowing stall chain; only a final beat needs room downstream
    assign out_free  = !out_valid_reg || m_ready;
    assign snap_free = !snap_valid_reg || out_free;
    assign in_adv    = in_valid_reg && (!in_reg.is_last || snap_free);
    assign in_free   = !in_valid_reg || in_adv;
    assign s_ready   = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_free) begin
            in_reg <= s_data;
        end
    end

    hbrp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (in_adv),
        .item    (in_reg),
        .st_next (st_next)
    );

    // capture the state as it stands after the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_free) begin
            snap_valid_reg <= in_adv && in_reg.is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && in_reg.is_last) begin
            snap_reg.st       <= st_next;
            snap_reg.file_len <= in_reg.file_len;
        end
    end

    hbrp_resolve u_resolve (
        .snap   (snap_reg),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid_reg && out_free) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/hbrp_checker.sv */
// Port-level checker for the byte-range parser, bound to the top level.
module hbrp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hbrp_pkg::hbrp_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input hbrp_pkg::hbrp_out_t m_data
);

    // final beats accepted whose result has not yet been taken
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = s_valid && s_ready && s_data.is_last;
    assign res_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (last_in && !res_out) begin
            pending_next = pending_reg + 3'd1;
        end else if (!last_in && res_out) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result beat without a final input beat");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.range_ok |-> m_data.first_byte == '0 && m_data.last_byte == '0)
        else $error("rejected range carries offsets");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.range_ok |-> m_data.first_byte <= m_data.last_byte)
        else $error("accepted range is inverted");

endmodule

bind http_byte_range_parser_unit hbrp_checker u_hbrp_checker (.*);
